// ===== rtl/c8_pkg.sv =====
// Shared types, codes and the hex font table for the instruction core.
// No dependencies; every other file imports this package.
`default_nettype none

package c8_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int ADDR_W    = 12;
	localparam int PC_W      = 13;
	localparam int FONT_LEN  = 80;

	// input word kinds
	localparam logic [1:0] IK_EXEC = 2'd0;
	localparam logic [1:0] IK_TICK = 2'd1;
	localparam logic [1:0] IK_LOAD = 2'd2;
	localparam logic [1:0] IK_COLL = 2'd3;

	// result word kinds
	localparam logic [1:0] RK_STEP  = 2'd0;
	localparam logic [1:0] RK_CLEAR = 2'd1;
	localparam logic [1:0] RK_ROW   = 2'd2;
	localparam logic [1:0] RK_HALT  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_OPC   = 3'd1;
	localparam logic [2:0] ERR_OVF   = 3'd2;
	localparam logic [2:0] ERR_UNF   = 3'd3;
	localparam logic [2:0] ERR_PC    = 3'd4;
	localparam logic [2:0] ERR_DIGIT = 3'd5;

	// major opcode nibbles
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [11:0] SYS_CLS = 12'h0E0;
	localparam logic [11:0] SYS_RET = 12'h0EE;

	// ALU sub-codes
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] KEY_SKP  = 8'h9E;
	localparam logic [7:0] KEY_SKNP = 8'hA1;

	localparam logic [7:0] FX_GETDT = 8'h07;
	localparam logic [7:0] FX_WAIT  = 8'h0A;
	localparam logic [7:0] FX_SETDT = 8'h15;
	localparam logic [7:0] FX_SETST = 8'h18;
	localparam logic [7:0] FX_ADDI  = 8'h1E;
	localparam logic [7:0] FX_FONT  = 8'h29;
	localparam logic [7:0] FX_BCD   = 8'h33;
	localparam logic [7:0] FX_STORE = 8'h55;
	localparam logic [7:0] FX_LOAD  = 8'h65;

	localparam logic [4:0] NO_KEY = 5'd16;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic       we;
		logic [3:0] waddr;
		logic [7:0] wdata;
		logic [3:0] raddr;
	} vrf_req_t;

endpackage

`default_nettype wire

// ===== rtl/c8_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on c8_pkg for the address width.
`default_nettype none

interface c8_item_if import c8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [ADDR_W-1:0] load_address;
	logic [7:0]        load_data;
	logic [15:0]       keys;
	logic [7:0]        random_byte;
	logic              collision;

	modport source (output valid, kind, load_address, load_data, keys, random_byte,
		collision, input ready);
	modport sink (input valid, kind, load_address, load_data, keys, random_byte,
		collision, output ready);
endinterface

interface c8_result_if import c8_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      result_kind;
	logic [PC_W-1:0] program_counter;
	logic [7:0]      sprite_x;
	logic [7:0]      sprite_y;
	logic [3:0]      row_index;
	logic [7:0]      row_data;
	logic [2:0]      error_code;
	logic            beep;
	logic            last;

	modport source (output valid, result_kind, program_counter, sprite_x, sprite_y,
		row_index, row_data, error_code, beep, last, input ready);
	modport sink (input valid, result_kind, program_counter, sprite_x, sprite_y,
		row_index, row_data, error_code, beep, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/c8_mem.sv =====
// 4 KiB main memory, one write and one registered read port.
// After reset a sweep loads the font and zeroes the rest. Uses c8_pkg.
`default_nettype none

module c8_mem import c8_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t req,
	output logic [7:0]    rdata,
	output logic          busy
);
	logic [7:0]        ram [MEM_BYTES];
	logic [ADDR_W:0]   clr_q;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              we;

	assign busy = !clr_q[ADDR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		if (busy) begin
			we    = 1'b1;
			waddr = clr_q[ADDR_W-1:0];
			wdata = (clr_q[ADDR_W-1:0] < ADDR_W'(FONT_LEN)) ? FONT[clr_q[6:0]] : 8'd0;
		end else begin
			we    = req.we;
			waddr = req.waddr;
			wdata = req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			ram[waddr] <= wdata;
		end
		rdata <= ram[req.raddr];
	end
endmodule

`default_nettype wire

// ===== rtl/c8_vrf.sv =====
// V register file: 16 bytes, one write and one registered read port.
// Per-entry valid bits make unwritten registers read as zero. Uses c8_pkg.
`default_nettype none

module c8_vrf import c8_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vrf_req_t req,
	output logic [7:0]    rdata
);
	logic [7:0]  regs [16];
	logic [15:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			regs[req.waddr] <= req.wdata;
		end
		rdata <= vld_q[req.raddr] ? regs[req.raddr] : 8'd0;
	end
endmodule

`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 instruction core: sequencer, call stack and output register.
// Input words arrive on 'item', result words leave on 'result' (valid/ready).
// Kind 0 runs one instruction, kind 1 is a refresh tick (timers count down),
// kind 2 writes one memory byte, kind 3 writes the display collision to VF.
// Every word yields one result with last set, except a draw, which yields
// one sprite-row result per row (up to 15), the last one marked.
// One word at a time: tick, load and collision go from dispatch to the result;
// an instruction makes two memory reads to fetch, three register file reads,
// one execute and one result step, plus a VF write for flag-setting 8XYN ops
// and a stack pop for 00EE. A draw reads and emits each row in turn, FX55/FX65
// read and write each register copied, FX33 writes three digits; an execute on
// a halted core or past the end of memory skips the fetch. The single read port
// of the register file and of the memory sets this order of steps. After reset
// the core loads the font and clears the 4096-byte memory, one byte per cycle,
// with ready low. Execution starts at PROGRAM_START. A stalled result holds in
// the output register; the next word is still taken and works until it has a
// result to hand over. Depends on c8_pkg, c8_if, c8_mem and c8_vrf.
`default_nettype none

module chip8_instruction_core import c8_pkg::*; #(
	parameter int STACK_DEPTH   = 48,
	parameter int PROGRAM_START = 512
) (
	input wire logic  clk,
	input wire logic  arst_n,
	c8_item_if.sink   item,
	c8_result_if.source result
);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SI_W = $clog2(STACK_DEPTH);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_FETCH0 = 5'd2;
	localparam logic [4:0] S_FETCH1 = 5'd3;
	localparam logic [4:0] S_FETCH2 = 5'd4;
	localparam logic [4:0] S_RVX    = 5'd5;
	localparam logic [4:0] S_RVY    = 5'd6;
	localparam logic [4:0] S_RV0    = 5'd7;
	localparam logic [4:0] S_EXEC   = 5'd8;
	localparam logic [4:0] S_WVF    = 5'd9;
	localparam logic [4:0] S_RET    = 5'd10;
	localparam logic [4:0] S_DRAW_RD = 5'd11;
	localparam logic [4:0] S_DRAW_EM = 5'd12;
	localparam logic [4:0] S_BCD_WR = 5'd13;
	localparam logic [4:0] S_ST_RD  = 5'd14;
	localparam logic [4:0] S_ST_WR  = 5'd15;
	localparam logic [4:0] S_LD_RD  = 5'd16;
	localparam logic [4:0] S_LD_WR  = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	logic [4:0] state_q;

	// captured input word
	logic [1:0]        kind_q;
	logic [ADDR_W-1:0] laddr_q;
	logic [7:0]        ldata_q;
	logic [15:0]       keys_q;
	logic [7:0]        rnd_q;
	logic              coll_q;

	// architectural state
	logic [PC_W-1:0] pc_q;
	logic [15:0]     idx_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]      dt_q;
	logic [7:0]      st_q;
	logic            refr_q;
	logic            was_refr_q;
	logic [4:0]      wkey_q;
	logic            halted_q;

	// instruction working registers
	logic [7:0] op_hi_q, op_lo_q;
	logic [7:0] vx_q, vy_q, v0_q;
	logic [3:0] o_q;
	logic       flag_q;
	logic [1:0] res_kind_q;
	logic [2:0] err_q;
	logic [7:0] bcd_h_q, bcd_t_q, bcd_u_q;

	// output register
	logic            ovalid_q;
	logic [1:0]      okind_q;
	logic [PC_W-1:0] opc_q;
	logic [7:0]      osx_q, osy_q, orow_q;
	logic [3:0]      oidx_q;
	logic [2:0]      oerr_q;
	logic            obeep_q, olast_q;
	logic            out_free;

	// call stack
	logic [PC_W-1:0] stk [STACK_DEPTH];
	logic [PC_W-1:0] stk_rd_q;
	logic [SI_W-1:0] stk_raddr;
	logic            stk_we;

	mem_req_t   mreq;
	vrf_req_t   vreq;
	logic [7:0] mem_rdata;
	logic [7:0] vrf_rdata;
	logic       mem_busy;

	// decode
	logic [3:0]      nib, fx, fy, fn;
	logic [7:0]      nn;
	logic [11:0]     nnn;
	logic [PC_W-1:0] pc2, pc4;
	logic [8:0]      sum9;
	logic [7:0]      alu_d;
	logic            alu_we, alu_fwe, alu_f;
	logic            vx_key, wkey_pressed;
	logic [4:0]      low_key;
	logic [1:0]      hund;
	logic [6:0]      rem100;
	logic [14:0]     prod;
	logic [3:0]      tens;
	logic [3:0]      units;
	logic            ex_we;
	logic [7:0]      ex_d;
	logic            stk_full;
	logic            row_last;
	logic [7:0]      bcd_dig;

	c8_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	c8_vrf u_vrf (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (vreq),
		.rdata (vrf_rdata)
	);

	assign nib = op_hi_q[7:4];
	assign fx  = op_hi_q[3:0];
	assign fy  = op_lo_q[7:4];
	assign fn  = op_lo_q[3:0];
	assign nn  = op_lo_q;
	assign nnn = {op_hi_q[3:0], op_lo_q};
	assign pc2 = pc_q + PC_W'(2);
	assign pc4 = pc_q + PC_W'(4);
	assign stk_full = (sp_q >= SP_W'(STACK_DEPTH));
	assign row_last = (o_q == fn - 4'd1);

	assign vx_key       = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
	assign wkey_pressed = !wkey_q[4] && keys_q[wkey_q[3:0]];

	always_comb begin
		low_key = NO_KEY;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				low_key = 5'(k);
			end
		end
	end

	// 8XYN
	always_comb begin
		sum9    = {1'b0, vx_q} + {1'b0, vy_q};
		alu_d   = vy_q;
		alu_we  = 1'b1;
		alu_fwe = 1'b0;
		alu_f   = 1'b0;
		case (fn)
			ALU_MOV: alu_d = vy_q;
			ALU_OR:  begin alu_d = vx_q | vy_q; alu_fwe = 1'b1; end
			ALU_AND: begin alu_d = vx_q & vy_q; alu_fwe = 1'b1; end
			ALU_XOR: begin alu_d = vx_q ^ vy_q; alu_fwe = 1'b1; end
			ALU_ADD: begin alu_d = sum9[7:0]; alu_fwe = 1'b1; alu_f = sum9[8]; end
			ALU_SUB: begin alu_d = vx_q - vy_q; alu_fwe = 1'b1; alu_f = (vy_q <= vx_q); end
			ALU_SHR: begin alu_d = {1'b0, vy_q[7:1]}; alu_fwe = 1'b1; alu_f = vy_q[0]; end
			ALU_RSB: begin alu_d = vy_q - vx_q; alu_fwe = 1'b1; alu_f = (vx_q <= vy_q); end
			ALU_SHL: begin alu_d = {vy_q[6:0], 1'b0}; alu_fwe = 1'b1; alu_f = vy_q[7]; end
			default: alu_we = 1'b0;
		endcase
	end

	// decimal digits of VX: tens by multiply with 205/2048
	always_comb begin
		if (vx_q >= 8'd200) begin
			hund = 2'd2;
		end else if (vx_q >= 8'd100) begin
			hund = 2'd1;
		end else begin
			hund = 2'd0;
		end
		rem100 = 7'(vx_q - 8'(hund) * 8'd100);
		prod   = 15'(rem100) * 15'd205;
		tens   = prod[14:11];
		units  = 4'(rem100 - 7'(tens) * 7'd10);
	end

	// register file write from the execute cycle
	always_comb begin
		ex_we = 1'b0;
		ex_d  = nn;
		case (nib)
			OP_LDI:  ex_we = 1'b1;
			OP_ADDI: begin ex_we = 1'b1; ex_d = vx_q + nn; end
			OP_ALU:  begin ex_we = alu_we; ex_d = alu_d; end
			OP_RND:  begin ex_we = 1'b1; ex_d = rnd_q & nn; end
			OP_MISC: begin
				if (nn == FX_GETDT) begin
					ex_we = 1'b1;
					ex_d  = dt_q;
				end else if (nn == FX_WAIT && !wkey_q[4] && !wkey_pressed) begin
					ex_we = 1'b1;
					ex_d  = {4'd0, wkey_q[3:0]};
				end
			end
			default: ex_we = 1'b0;
		endcase
	end

	always_comb begin
		case (o_q[1:0])
			2'd0:    bcd_dig = bcd_h_q;
			2'd1:    bcd_dig = bcd_t_q;
			default: bcd_dig = bcd_u_q;
		endcase
	end

	// memory port
	always_comb begin
		mreq.we    = 1'b0;
		mreq.waddr = idx_q[ADDR_W-1:0];
		mreq.wdata = vrf_rdata;
		case (state_q)
			S_FETCH1:             mreq.raddr = pc_q[ADDR_W-1:0] + 1'b1;
			S_DRAW_RD, S_DRAW_EM: mreq.raddr = idx_q[ADDR_W-1:0] + ADDR_W'(o_q);
			S_LD_RD:              mreq.raddr = idx_q[ADDR_W-1:0];
			default:              mreq.raddr = pc_q[ADDR_W-1:0];
		endcase
		case (state_q)
			S_DISP: begin
				mreq.we    = (kind_q == IK_LOAD);
				mreq.waddr = laddr_q;
				mreq.wdata = ldata_q;
			end
			S_ST_WR: mreq.we = 1'b1;
			S_BCD_WR: begin
				mreq.we    = 1'b1;
				mreq.waddr = idx_q[ADDR_W-1:0] + ADDR_W'(o_q);
				mreq.wdata = bcd_dig;
			end
			default: mreq.we = 1'b0;
		endcase
	end

	// register file port
	always_comb begin
		vreq.we    = 1'b0;
		vreq.waddr = fx;
		vreq.wdata = ex_d;
		case (state_q)
			S_FETCH2: vreq.raddr = op_hi_q[3:0];
			S_RVX:    vreq.raddr = fy;
			S_ST_RD:  vreq.raddr = o_q;
			default:  vreq.raddr = 4'd0;
		endcase
		case (state_q)
			S_DISP: begin
				vreq.we    = (kind_q == IK_COLL);
				vreq.waddr = 4'hF;
				vreq.wdata = {7'd0, coll_q};
			end
			S_EXEC: vreq.we = ex_we;
			S_WVF: begin
				vreq.we    = 1'b1;
				vreq.waddr = 4'hF;
				vreq.wdata = {7'd0, flag_q};
			end
			S_LD_WR: begin
				vreq.we    = 1'b1;
				vreq.waddr = o_q;
				vreq.wdata = mem_rdata;
			end
			default: vreq.we = 1'b0;
		endcase
	end

	// call stack
	assign stk_we    = (state_q == S_EXEC) && (nib == OP_CALL) && !stk_full;
	assign stk_raddr = (sp_q == '0) ? '0 : SI_W'(sp_q - 1'b1);

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[SI_W'(sp_q)] <= pc2;
		end
		stk_rd_q <= stk[stk_raddr];
	end

	assign item.ready = (state_q == S_IDLE) && !mem_busy;
	assign out_free   = !ovalid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= IK_EXEC;
			laddr_q    <= '0;
			ldata_q    <= '0;
			keys_q     <= '0;
			rnd_q      <= '0;
			coll_q     <= 1'b0;
			pc_q       <= PC_W'(PROGRAM_START);
			idx_q      <= '0;
			sp_q       <= '0;
			dt_q       <= '0;
			st_q       <= '0;
			refr_q     <= 1'b0;
			was_refr_q <= 1'b0;
			wkey_q     <= NO_KEY;
			halted_q   <= 1'b0;
			op_hi_q    <= '0;
			op_lo_q    <= '0;
			vx_q       <= '0;
			vy_q       <= '0;
			v0_q       <= '0;
			o_q        <= '0;
			flag_q     <= 1'b0;
			res_kind_q <= RK_STEP;
			err_q      <= ERR_NONE;
			bcd_h_q    <= '0;
			bcd_t_q    <= '0;
			bcd_u_q    <= '0;
			ovalid_q   <= 1'b0;
			okind_q    <= RK_STEP;
			opc_q      <= '0;
			osx_q      <= '0;
			osy_q      <= '0;
			orow_q     <= '0;
			oidx_q     <= '0;
			oerr_q     <= ERR_NONE;
			obeep_q    <= 1'b0;
			olast_q    <= 1'b0;
		end else begin
			if (ovalid_q && result.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid && item.ready) begin
						kind_q     <= item.kind;
						laddr_q    <= item.load_address;
						ldata_q    <= item.load_data;
						keys_q     <= item.keys;
						rnd_q      <= item.random_byte;
						coll_q     <= item.collision;
						res_kind_q <= RK_STEP;
						err_q      <= ERR_NONE;
						state_q    <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_DONE;
					case (kind_q)
						IK_EXEC: state_q <= S_FETCH0;
						IK_TICK: begin
							if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
							if (st_q != 8'd0) st_q <= st_q - 8'd1;
							refr_q <= 1'b1;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FETCH0: begin
					if (halted_q) begin
						res_kind_q <= RK_HALT;
						state_q    <= S_DONE;
					end else begin
						refr_q     <= 1'b0;
						was_refr_q <= refr_q;
						if (pc_q[PC_W-1]) begin
							res_kind_q <= RK_HALT;
							err_q      <= ERR_PC;
							halted_q   <= 1'b1;
							state_q    <= S_DONE;
						end else begin
							state_q <= S_FETCH1;
						end
					end
				end
				S_FETCH1: begin
					op_hi_q <= mem_rdata;
					state_q <= S_FETCH2;
				end
				S_FETCH2: begin
					op_lo_q <= mem_rdata;
					state_q <= S_RVX;
				end
				S_RVX: begin
					vx_q    <= vrf_rdata;
					state_q <= S_RVY;
				end
				S_RVY: begin
					vy_q    <= vrf_rdata;
					state_q <= S_RV0;
				end
				S_RV0: begin
					v0_q    <= vrf_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pc_q    <= pc2;
					state_q <= S_DONE;
					case (nib)
						OP_SYS: begin
							if (nnn == SYS_CLS) begin
								res_kind_q <= RK_CLEAR;
							end else if (nnn == SYS_RET) begin
								if (sp_q == '0) begin
									pc_q       <= pc_q;
									res_kind_q <= RK_HALT;
									err_q      <= ERR_UNF;
									halted_q   <= 1'b1;
								end else begin
									sp_q    <= sp_q - 1'b1;
									state_q <= S_RET;
								end
							end else begin
								pc_q       <= pc_q;
								res_kind_q <= RK_HALT;
								err_q      <= ERR_OPC;
								halted_q   <= 1'b1;
							end
						end
						OP_JP: pc_q <= {1'b0, nnn};
						OP_CALL: begin
							if (stk_full) begin
								pc_q       <= pc_q;
								res_kind_q <= RK_HALT;
								err_q      <= ERR_OVF;
								halted_q   <= 1'b1;
							end else begin
								sp_q <= sp_q + 1'b1;
								pc_q <= {1'b0, nnn};
							end
						end
						OP_SEI:  if (vx_q == nn) pc_q <= pc4;
						OP_SNEI: if (vx_q != nn) pc_q <= pc4;
						OP_SER:  if (vx_q == vy_q) pc_q <= pc4;
						OP_SNER: if (vx_q != vy_q) pc_q <= pc4;
						OP_ALU: begin
							if (alu_fwe) begin
								flag_q  <= alu_f;
								state_q <= S_WVF;
							end
						end
						OP_LDIX: idx_q <= {4'd0, nnn};
						OP_JPV0: pc_q <= PC_W'(v0_q) + {1'b0, nnn};
						OP_DRW: begin
							if (!was_refr_q) begin
								pc_q <= pc_q;
							end else if (fn != 4'd0) begin
								o_q     <= '0;
								state_q <= S_DRAW_RD;
							end
						end
						OP_KEY: begin
							if (nn == KEY_SKP) begin
								if (vx_key) pc_q <= pc4;
							end else if (nn == KEY_SKNP) begin
								if (!vx_key) pc_q <= pc4;
							end else begin
								pc_q       <= pc_q;
								res_kind_q <= RK_HALT;
								err_q      <= ERR_OPC;
								halted_q   <= 1'b1;
							end
						end
						OP_MISC: begin
							case (nn)
								FX_GETDT: ;
								FX_WAIT: begin
									if (wkey_q[4]) begin
										wkey_q <= low_key;
										pc_q   <= pc_q;
									end else if (wkey_pressed) begin
										pc_q <= pc_q;
									end else begin
										wkey_q <= NO_KEY;
									end
								end
								FX_SETDT: dt_q <= vx_q;
								FX_SETST: st_q <= vx_q;
								FX_ADDI:  idx_q <= idx_q + {8'd0, vx_q};
								FX_FONT: begin
									if (vx_q[7:4] != 4'd0) begin
										pc_q       <= pc_q;
										res_kind_q <= RK_HALT;
										err_q      <= ERR_DIGIT;
										halted_q   <= 1'b1;
									end else begin
										idx_q <= {9'd0, {1'b0, vx_q[3:0], 2'b00} + 7'(vx_q[3:0])};
									end
								end
								FX_BCD: begin
									bcd_h_q <= {6'd0, hund};
									bcd_t_q <= {4'd0, tens};
									bcd_u_q <= {4'd0, units};
									o_q     <= '0;
									state_q <= S_BCD_WR;
								end
								FX_STORE: begin
									o_q     <= '0;
									state_q <= S_ST_RD;
								end
								FX_LOAD: begin
									o_q     <= '0;
									state_q <= S_LD_RD;
								end
								default: begin
									pc_q       <= pc_q;
									res_kind_q <= RK_HALT;
									err_q      <= ERR_OPC;
									halted_q   <= 1'b1;
								end
							endcase
						end
						default: ;
					endcase
				end
				S_WVF: state_q <= S_DONE;
				S_RET: begin
					pc_q    <= stk_rd_q;
					state_q <= S_DONE;
				end
				S_DRAW_RD: state_q <= S_DRAW_EM;
				S_DRAW_EM: begin
					// hold the row until the output register frees up
					if (out_free) begin
						ovalid_q <= 1'b1;
						okind_q  <= RK_ROW;
						opc_q    <= pc_q;
						osx_q    <= vx_q;
						osy_q    <= vy_q;
						oidx_q   <= o_q;
						orow_q   <= mem_rdata;
						oerr_q   <= ERR_NONE;
						obeep_q  <= (st_q != 8'd0);
						olast_q  <= row_last;
						if (row_last) begin
							state_q <= S_IDLE;
						end else begin
							o_q     <= o_q + 4'd1;
							state_q <= S_DRAW_RD;
						end
					end
				end
				S_BCD_WR: begin
					if (o_q == 4'd2) begin
						state_q <= S_DONE;
					end else begin
						o_q <= o_q + 4'd1;
					end
				end
				S_ST_RD: state_q <= S_ST_WR;
				S_ST_WR: begin
					idx_q <= idx_q + 16'd1;
					if (o_q == fx) begin
						state_q <= S_DONE;
					end else begin
						o_q     <= o_q + 4'd1;
						state_q <= S_ST_RD;
					end
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: begin
					idx_q <= idx_q + 16'd1;
					if (o_q == fx) begin
						state_q <= S_DONE;
					end else begin
						o_q     <= o_q + 4'd1;
						state_q <= S_LD_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						okind_q  <= res_kind_q;
						opc_q    <= pc_q;
						osx_q    <= '0;
						osy_q    <= '0;
						oidx_q   <= '0;
						orow_q   <= '0;
						oerr_q   <= err_q;
						obeep_q  <= (st_q != 8'd0);
						olast_q  <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid           = ovalid_q;
	assign result.result_kind     = okind_q;
	assign result.program_counter = opc_q;
	assign result.sprite_x        = osx_q;
	assign result.sprite_y        = osy_q;
	assign result.row_index       = oidx_q;
	assign result.row_data        = orow_q;
	assign result.error_code      = oerr_q;
	assign result.beep            = obeep_q;
	assign result.last            = olast_q;
endmodule

`default_nettype wire

// ===== bench/tb_chip8_instruction_core.sv =====
// Self-checking bench for chip8_instruction_core: programs are loaded byte by byte and stepped,
// every result word is checked against a behavioral model of the core kept in this file.
// Depends on c8_pkg, c8_if and the core RTL.
`timescale 1ns / 100ps

module tb_chip8_instruction_core;
	import c8_pkg::*;

	localparam int STACK_LIMIT = 48;
	localparam int WORD_TARGET = 360;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] load_address;
		logic [7:0]  load_data;
		logic [15:0] keys;
		logic [7:0]  random_byte;
		logic        collision;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [12:0] program_counter;
		logic [7:0]  sprite_x;
		logic [7:0]  sprite_y;
		logic [3:0]  row_index;
		logic [7:0]  row_data;
		logic [2:0]  error_code;
		logic        beep;
		logic        last;
	} report_t;

	logic clk;
	logic arst_n;

	c8_item_if   item_bus ();
	c8_result_if result_bus ();

	chip8_instruction_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	always #5 clk = ~clk;

	// core state as the bench sees it
	logic [7:0]  ram [MEM_BYTES];
	logic [7:0]  vreg [16];
	logic [12:0] ret_stack [STACK_LIMIT];
	int          depth;
	logic [12:0] pc_now;
	logic [15:0] index_now;
	logic [7:0]  delay_now;
	logic [7:0]  sound_now;
	logic        refresh_seen;
	logic [4:0]  latched_key;
	logic        is_halted;

	cmd_t    cmd_queue [$];
	report_t expected_reports [$];
	int      words_sent;
	int      reports_checked;
	int      error_count;
	int      fault_kind;
	logic    long_hold;

	function automatic void add_report(logic [1:0] rk, logic [7:0] sx, logic [7:0] sy,
		logic [3:0] row, logic [7:0] rdata, logic [2:0] err, logic last);
		report_t r;
		r.result_kind = rk;
		r.program_counter = pc_now;
		r.sprite_x = sx;
		r.sprite_y = sy;
		r.row_index = row;
		r.row_data = rdata;
		r.error_code = err;
		r.beep = (sound_now != 8'd0);
		r.last = last;
		expected_reports.push_back(r);
	endfunction

	function automatic void halt_core(logic [12:0] at, logic [2:0] code);
		pc_now = at;
		is_halted = 1'b1;
		add_report(RK_HALT, 8'd0, 8'd0, 4'd0, 8'd0, code, 1'b1);
	endfunction

	function automatic void run_instruction(cmd_t c);
		logic [12:0] at;
		logic        was_refreshed;
		logic [15:0] op;
		logic [11:0] nnn;
		logic [7:0]  nn, a, b;
		logic [3:0]  n, x, y;
		logic [8:0]  sum;
		at = pc_now;
		was_refreshed = refresh_seen;
		if (is_halted) begin
			add_report(RK_HALT, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
			return;
		end
		refresh_seen = 1'b0;
		if (pc_now >= 13'(MEM_BYTES)) begin
			halt_core(at, ERR_PC);
			return;
		end
		op = {ram[pc_now[11:0]], ram[pc_now[11:0] + 12'd1]};
		nnn = op[11:0];
		nn = op[7:0];
		n = op[3:0];
		x = op[11:8];
		y = op[7:4];
		a = vreg[x];
		b = vreg[y];
		pc_now = pc_now + 13'd2;
		case (op[15:12])
			OP_SYS: begin
				if (nnn == SYS_CLS) begin
					add_report(RK_CLEAR, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
					return;
				end else if (nnn == SYS_RET) begin
					if (depth == 0) begin
						halt_core(at, ERR_UNF);
						return;
					end
					depth--;
					pc_now = ret_stack[depth];
				end else begin
					halt_core(at, ERR_OPC);
					return;
				end
			end
			OP_JP: pc_now = {1'b0, nnn};
			OP_CALL: begin
				if (depth >= STACK_LIMIT) begin
					halt_core(at, ERR_OVF);
					return;
				end
				ret_stack[depth] = pc_now;
				depth++;
				pc_now = {1'b0, nnn};
			end
			OP_SEI:  if (a == nn) pc_now = pc_now + 13'd2;
			OP_SNEI: if (a != nn) pc_now = pc_now + 13'd2;
			OP_SER:  if (a == b) pc_now = pc_now + 13'd2;
			OP_LDI:  vreg[x] = nn;
			OP_ADDI: vreg[x] = a + nn;
			OP_ALU: begin
				case (n)
					ALU_MOV: vreg[x] = b;
					ALU_OR:  begin vreg[x] = a | b; vreg[15] = 8'd0; end
					ALU_AND: begin vreg[x] = a & b; vreg[15] = 8'd0; end
					ALU_XOR: begin vreg[x] = a ^ b; vreg[15] = 8'd0; end
					ALU_ADD: begin
						sum = {1'b0, a} + {1'b0, b};
						vreg[x] = sum[7:0];
						vreg[15] = {7'd0, sum[8]};
					end
					ALU_SUB: begin vreg[x] = a - b; vreg[15] = {7'd0, b <= a}; end
					ALU_SHR: begin vreg[x] = b >> 1; vreg[15] = {7'd0, b[0]}; end
					ALU_RSB: begin vreg[x] = b - a; vreg[15] = {7'd0, a <= b}; end
					ALU_SHL: begin vreg[x] = b << 1; vreg[15] = {7'd0, b[7]}; end
					default: ;
				endcase
			end
			OP_SNER: if (a != b) pc_now = pc_now + 13'd2;
			OP_LDIX: index_now = {4'd0, nnn};
			OP_JPV0: pc_now = 13'(vreg[0]) + 13'(nnn);
			OP_RND:  vreg[x] = c.random_byte & nn;
			OP_DRW: begin
				if (!was_refreshed) begin
					pc_now = at;
				end else if (n != 4'd0) begin
					for (int o = 0; o < n; o++)
						add_report(RK_ROW, a, b, 4'(o), ram[12'(index_now + 16'(o))],
							ERR_NONE, o + 1 == n);
					return;
				end
			end
			OP_KEY: begin
				if (nn == KEY_SKP) begin
					if (a < 8'd16 && c.keys[a[3:0]]) pc_now = pc_now + 13'd2;
				end else if (nn == KEY_SKNP) begin
					if (!(a < 8'd16 && c.keys[a[3:0]])) pc_now = pc_now + 13'd2;
				end else begin
					halt_core(at, ERR_OPC);
					return;
				end
			end
			default: begin
				case (nn)
					FX_GETDT: vreg[x] = delay_now;
					FX_WAIT: begin
						if (latched_key >= NO_KEY) begin
							latched_key = NO_KEY;
							for (int o = 15; o >= 0; o--)
								if (c.keys[o]) latched_key = 5'(o);
							pc_now = at;
						end else if (c.keys[latched_key[3:0]]) begin
							pc_now = at;
						end else begin
							vreg[x] = {3'd0, latched_key};
							latched_key = NO_KEY;
						end
					end
					FX_SETDT: delay_now = a;
					FX_SETST: sound_now = a;
					FX_ADDI:  index_now = index_now + 16'(a);
					FX_FONT: begin
						if (a >= 8'd16) begin
							halt_core(at, ERR_DIGIT);
							return;
						end
						index_now = 16'(a) * 16'd5;
					end
					FX_BCD: begin
						ram[index_now[11:0]] = a / 8'd100;
						ram[12'(index_now + 16'd1)] = (a / 8'd10) % 8'd10;
						ram[12'(index_now + 16'd2)] = a % 8'd10;
					end
					FX_STORE:
						for (int o = 0; o <= x; o++) begin
							ram[index_now[11:0]] = vreg[o];
							index_now = index_now + 16'd1;
						end
					FX_LOAD:
						for (int o = 0; o <= x; o++) begin
							vreg[o] = ram[index_now[11:0]];
							index_now = index_now + 16'd1;
						end
					default: begin
						halt_core(at, ERR_OPC);
						return;
					end
				endcase
			end
		endcase
		add_report(RK_STEP, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
	endfunction

	// queue one word and advance the model by it
	function automatic void send_word(cmd_t c);
		cmd_queue.push_back(c);
		case (c.kind)
			IK_EXEC: run_instruction(c);
			IK_TICK: begin
				if (delay_now != 8'd0) delay_now--;
				if (sound_now != 8'd0) sound_now--;
				refresh_seen = 1'b1;
				add_report(RK_STEP, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
			end
			IK_LOAD: begin
				ram[c.load_address] = c.load_data;
				add_report(RK_STEP, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
			end
			default: begin
				vreg[15] = {7'd0, c.collision};
				add_report(RK_STEP, 8'd0, 8'd0, 4'd0, 8'd0, ERR_NONE, 1'b1);
			end
		endcase
	endfunction

	function automatic cmd_t make_word(logic [1:0] kind, logic [11:0] addr, logic [7:0] data);
		cmd_t c;
		c.kind = kind;
		c.load_address = addr;
		c.load_data = data;
		c.keys = 16'($urandom);
		c.random_byte = 8'($urandom);
		c.collision = 1'($urandom);
		return c;
	endfunction

	// place the opcode at pc (only the bytes that differ) and execute it
	function automatic void step_op(logic [15:0] op, logic [15:0] keys);
		cmd_t c;
		if (ram[pc_now[11:0]] != op[15:8])
			send_word(make_word(IK_LOAD, pc_now[11:0], op[15:8]));
		if (ram[pc_now[11:0] + 12'd1] != op[7:0])
			send_word(make_word(IK_LOAD, pc_now[11:0] + 12'd1, op[7:0]));
		c = make_word(IK_EXEC, 12'd0, 8'd0);
		c.keys = keys;
		send_word(c);
	endfunction

	function automatic logic [15:0] safe_opcode();
		logic [15:0] op;
		logic [7:0]  fx_codes [9];
		fx_codes = '{FX_GETDT, FX_WAIT, FX_SETDT, FX_SETST, FX_ADDI, FX_FONT, FX_BCD,
			FX_STORE, FX_LOAD};
		op = 16'($urandom);
		case (op[15:12])
			OP_SYS:  op[11:0] = (depth > 0 && op[0]) ? SYS_RET : SYS_CLS;
			OP_CALL: if (depth >= STACK_LIMIT) op = {OP_SYS, SYS_RET};
			OP_JPV0: if (13'(vreg[0]) + 13'(op[11:0]) >= 13'hF00) op[11] = 1'b0;
			OP_KEY:  op[7:0] = op[8] ? KEY_SKP : KEY_SKNP;
			OP_MISC: begin
				op[7:0] = fx_codes[$urandom_range(0, 8)];
				if (op[7:0] == FX_FONT && vreg[op[11:8]] >= 8'd16) op[7:0] = FX_ADDI;
			end
			default: ;
		endcase
		return op;
	endfunction

	function automatic int pick_gap(int sent);
		int r;
		r = $urandom_range(0, 99);
		if ((sent / 40) % 3 == 0) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender: present the next word once the current one is taken
	int send_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_bus.valid && item_bus.ready) words_sent <= words_sent + 1;
			if (!item_bus.valid || item_bus.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_bus.valid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					cmd_t c;
					c = cmd_queue.pop_front();
					item_bus.kind <= c.kind;
					item_bus.load_address <= c.load_address;
					item_bus.load_data <= c.load_data;
					item_bus.keys <= c.keys;
					item_bus.random_byte <= c.random_byte;
					item_bus.collision <= c.collision;
					item_bus.valid <= 1'b1;
					send_gap <= pick_gap(words_sent);
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	function automatic string show(report_t r);
		return $sformatf("kind=%0d pc=%h x=%h y=%h row=%0d data=%h err=%0d beep=%0b last=%0b",
			r.result_kind, r.program_counter, r.sprite_x, r.sprite_y, r.row_index,
			r.row_data, r.error_code, r.beep, r.last);
	endfunction

	// receiver: random stalls, plus the long hold-off
	int stall_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				report_t got;
				got = {result_bus.result_kind, result_bus.program_counter, result_bus.sprite_x,
					result_bus.sprite_y, result_bus.row_index, result_bus.row_data,
					result_bus.error_code, result_bus.beep, result_bus.last};
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result word: %s", $time, show(got));
					error_count <= error_count + 1;
				end else begin
					report_t want;
					want = expected_reports.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
							show(want), show(got));
						error_count <= error_count + 1;
					end
				end
				reports_checked <= reports_checked + 1;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= !long_hold;
				stall_left <= pick_gap(reports_checked + 20);
			end
		end
	end

	initial begin
		long_hold = 1'b0;
		wait (words_sent >= 150);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.kind = IK_TICK;
		item_bus.load_address = '0;
		item_bus.load_data = '0;
		item_bus.keys = '0;
		item_bus.random_byte = '0;
		item_bus.collision = 1'b0;
		result_bus.ready = 1'b0;
		words_sent = 0;
		reports_checked = 0;
		error_count = 0;
		send_gap = 0;
		stall_left = 0;

		for (int i = 0; i < MEM_BYTES; i++) ram[i] = (i < FONT_LEN) ? FONT[i] : 8'd0;
		for (int i = 0; i < 16; i++) vreg[i] = 8'd0;
		depth = 0;
		pc_now = 13'(512);
		index_now = '0;
		delay_now = '0;
		sound_now = '0;
		refresh_seen = 1'b0;
		latched_key = NO_KEY;
		is_halted = 1'b0;

		// directed: arithmetic extremes, flags, draw gating, key wait, range keys
		step_op(16'h00E0, 16'h0000);
		step_op(16'h6AFF, 16'hFFFF);
		step_op(16'h7A02, 16'h0000);
		step_op(16'h6BFF, 16'h0000);
		step_op(16'h8AB4, 16'h0000);
		step_op(16'h8AB5, 16'h0000);
		step_op(16'h8AB7, 16'h0000);
		step_op(16'h8AB6, 16'h0000);
		step_op(16'h8ABE, 16'h0000);
		step_op(16'hDAB3, 16'h0000);
		send_word(make_word(IK_TICK, 12'd0, 8'd0));
		step_op(16'hDABF, 16'h0000);
		c = make_word(IK_COLL, 12'hFFF, 8'hFF);
		c.collision = 1'b1;
		send_word(c);
		step_op(16'hF30A, 16'h0000);
		step_op(16'hF30A, 16'h8020);
		step_op(16'hF30A, 16'h0020);
		step_op(16'hF30A, 16'h0000);
		step_op(16'h6120, 16'h0000);
		step_op(16'hE19E, 16'hFFFF);
		send_word(make_word(IK_LOAD, 12'h000, 8'h00));

		// random programs with ticks, collisions and stray loads mixed in
		while (cmd_queue.size() < WORD_TARGET) begin
			int r;
			r = $urandom_range(0, 99);
			if (pc_now >= 13'hFF0)
				step_op({OP_JP, 12'(12'h200 + $urandom_range(0, 12'hB00))}, 16'($urandom));
			else if (r < 70)
				step_op(safe_opcode(), 16'($urandom));
			else if (r < 85)
				send_word(make_word(IK_TICK, 12'd0, 8'd0));
			else if (r < 92)
				send_word(make_word(IK_COLL, 12'd0, 8'd0));
			else
				send_word(make_word(IK_LOAD, 12'($urandom), 8'($urandom)));
		end

		// one fault halts the core for good, so take one kind per run
		fault_kind = $urandom_range(1, 5);
		case (fault_kind)
			1: step_op(16'h0123, 16'h0000);
			2: while (!is_halted) step_op({OP_CALL, pc_now[11:0]}, 16'h0000);
			3: while (!is_halted) step_op({OP_SYS, SYS_RET}, 16'h0000);
			4: begin
				step_op(16'h60FF, 16'h0000);
				step_op(16'hBFFF, 16'h0000);
				step_op(16'h00E0, 16'h0000);
			end
			default: begin
				step_op(16'h6210, 16'h0000);
				step_op(16'hF229, 16'h0000);
			end
		endcase
		step_op(16'h6001, 16'h0000);
		send_word(make_word(IK_TICK, 12'd0, 8'd0));
		send_word(make_word(IK_LOAD, 12'hABC, 8'h5A));
		send_word(make_word(IK_COLL, 12'd0, 8'd0));
		send_word(make_word(IK_EXEC, 12'd0, 8'd0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_queue.size() != 0 || item_bus.valid) @(posedge clk);
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Ran %0d input words and checked %0d result words;", words_sent,
			reports_checked);
		$display("the run ended on fault kind %0d with the core halted.", fault_kind);
		if (error_count == 0 && expected_reports.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
